@@ design/pmac_pkg.sv @@
// shared types and constants for the pointer motion acceleration curve block
// no dependencies; imported by every design file
`default_nettype none

package pmac_pkg;

   // divider operand widths: numerator magnitude and divisor
   localparam int NUM_W  = 34;
   localparam int DEN_W  = 28;
   localparam int CNT_W  = $clog2(NUM_W);
   localparam int ADDR_W = 5;

   // register indexes (byte address bits [4:2])
   localparam logic [2:0] REG_PAD_SPEED_GAIN  = 3'd0;
   localparam logic [2:0] REG_PAD_ACCEL_GAIN  = 3'd1;
   localparam logic [2:0] REG_GYRO_SPEED_GAIN = 3'd2;
   localparam logic [2:0] REG_GYRO_ACCEL_GAIN = 3'd3;
   localparam logic [2:0] REG_DRAG_DIVISOR    = 3'd4;
   localparam logic [2:0] REG_TILT_MIX_GAIN   = 3'd5;

   // register reset values
   localparam logic [15:0] RST_PAD_SPEED_GAIN  = 16'd2500;
   localparam logic [9:0]  RST_PAD_ACCEL_GAIN  = 10'd150;
   localparam logic [11:0] RST_GYRO_SPEED_GAIN = 12'd500;
   localparam logic [7:0]  RST_GYRO_ACCEL_GAIN = 8'd20;
   localparam logic [7:0]  RST_DRAG_DIVISOR    = 8'd20;
   localparam logic [7:0]  RST_TILT_MIX_GAIN   = 8'd10;

   localparam logic [7:0]  PAD_CENTRE         = 8'd127;
   localparam logic [16:0] DRAG_RADIUS_SQ_MIN = 17'd9901;

   typedef struct packed {
      logic [15:0] pad_speed_gain;
      logic [9:0]  pad_accel_gain;
      logic [11:0] gyro_speed_gain;
      logic [7:0]  gyro_accel_gain;
      logic [7:0]  drag_divisor;
      logic [7:0]  tilt_mix_gain;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic save_pad;
      logic mul1;
      logic mul2;
      logic div_start;
      logic out_load;
      logic drag;
      logic zero;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic gyro_mode;
      logic pad_zero;
      logic drag_hit;
      logic div_done;
   } status_type;

endpackage

`default_nettype wire

@@ design/pointer_motion_accel_curve_top.sv @@
// top level: configuration registers, controller and datapath
// depends on pmac_pkg, pmac_ctrl, pmac_dp (and pmac_div below it)
`default_nettype none

//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------------------
//  req      | in        | req_valid / req_stall     | mode, pad x/y, pressed, gyro,
//           |           |                           | tilt, interval
//  rsp      | out       | rsp_valid / rsp_stall     | rsp_move_x, rsp_move_y
//  csr      | in/out    | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
//  one item at a time: a moving item runs PREP1, PREP2 and PREP3 (products and
//  operand forming) after accept, then the 34-step restoring dividers (x and y
//  run side by side), S_DIV to see done and S_WRITE to load the result
//  items that move nothing (untouched pad, first touch, first gyro sample)
//  go from PREP1 straight to S_WRITE and load their zero result
//  the result sits in an output register; while it is stalled the next item
//  is accepted and worked on, and waits only for the final register load
//  reset is synchronous and clears tracking state and restores register defaults

module pointer_motion_accel_curve_top import pmac_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // item input
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_gyro_mode,
   input  logic [7:0]        req_pad_x,
   input  logic [7:0]        req_pad_y,
   input  logic              req_pad_pressed,
   input  logic signed [12:0] req_rate_yaw,
   input  logic signed [12:0] req_rate_pitch,
   input  logic signed [12:0] req_tilt_x,
   input  logic signed [12:0] req_tilt_z,
   input  logic [15:0]       req_interval,
   // result output
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [7:0] rsp_move_x,
   output logic signed [7:0] rsp_move_y,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   cmd_type    cmd;
   status_type status;
   logic       csr_write;
   logic [2:0] reg_idx;

   // register file; accesses decode on the word index only
   assign pready    = 1'b1;
   assign reg_idx   = paddr[ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_idx)
            REG_PAD_SPEED_GAIN:  cfg_in.pad_speed_gain  = pwdata[15:0];
            REG_PAD_ACCEL_GAIN:  cfg_in.pad_accel_gain  = pwdata[9:0];
            REG_GYRO_SPEED_GAIN: cfg_in.gyro_speed_gain = pwdata[11:0];
            REG_GYRO_ACCEL_GAIN: cfg_in.gyro_accel_gain = pwdata[7:0];
            REG_DRAG_DIVISOR:    cfg_in.drag_divisor    = pwdata[7:0];
            REG_TILT_MIX_GAIN:   cfg_in.tilt_mix_gain   = pwdata[7:0];
            default: begin
               // unmapped index, write ignored
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pad_speed_gain  <= RST_PAD_SPEED_GAIN;
         cfg_ff.pad_accel_gain  <= RST_PAD_ACCEL_GAIN;
         cfg_ff.gyro_speed_gain <= RST_GYRO_SPEED_GAIN;
         cfg_ff.gyro_accel_gain <= RST_GYRO_ACCEL_GAIN;
         cfg_ff.drag_divisor    <= RST_DRAG_DIVISOR;
         cfg_ff.tilt_mix_gain   <= RST_TILT_MIX_GAIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back, zero-extended
   always_comb begin
      unique case (reg_idx)
         REG_PAD_SPEED_GAIN:  prdata = {16'b0, cfg_ff.pad_speed_gain};
         REG_PAD_ACCEL_GAIN:  prdata = {22'b0, cfg_ff.pad_accel_gain};
         REG_GYRO_SPEED_GAIN: prdata = {20'b0, cfg_ff.gyro_speed_gain};
         REG_GYRO_ACCEL_GAIN: prdata = {24'b0, cfg_ff.gyro_accel_gain};
         REG_DRAG_DIVISOR:    prdata = {24'b0, cfg_ff.drag_divisor};
         REG_TILT_MIX_GAIN:   prdata = {24'b0, cfg_ff.tilt_mix_gain};
         default:             prdata = '0;
      endcase
   end

   // sequencing: decides the path per item and holds tracking state
   pmac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic: products, operand forming, dividers, saturation
   pmac_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cfg             (cfg_ff),
      .req_gyro_mode   (req_gyro_mode),
      .req_pad_x       (req_pad_x),
      .req_pad_y       (req_pad_y),
      .req_pad_pressed (req_pad_pressed),
      .req_rate_yaw    (req_rate_yaw),
      .req_rate_pitch  (req_rate_pitch),
      .req_tilt_x      (req_tilt_x),
      .req_tilt_z      (req_tilt_z),
      .req_interval    (req_interval),
      .status          (status),
      .rsp_move_x      (rsp_move_x),
      .rsp_move_y      (rsp_move_y)
   );

endmodule

`default_nettype wire

@@ design/pmac_div.sv @@
// restoring divider, one quotient bit per cycle, unsigned operands
// depends on pmac_pkg
`default_nettype none

module pmac_div import pmac_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quot,
   output logic             done
);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_nx;
   logic             fits;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[NUM_W-1]};
      fits   = rem_sh >= {1'b0, den_ff};
      rem_nx = fits ? (rem_sh - {1'b0, den_ff}) : rem_sh;
      rem_in = rem_nx[DEN_W-1:0];
      quo_in = {quo_ff[NUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_W'(NUM_W - 1);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quot = quo_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

@@ design/pmac_dp.sv @@
// datapath: input capture, gain and square products, operand forming,
// two dividers and the result register; depends on pmac_pkg and pmac_div
`default_nettype none

module pmac_dp import pmac_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  cfg_type           cfg,
   input  logic              req_gyro_mode,
   input  logic [7:0]        req_pad_x,
   input  logic [7:0]        req_pad_y,
   input  logic              req_pad_pressed,
   input  logic signed [12:0] req_rate_yaw,
   input  logic signed [12:0] req_rate_pitch,
   input  logic signed [12:0] req_tilt_x,
   input  logic signed [12:0] req_tilt_z,
   input  logic [15:0]       req_interval,
   output status_type        status,
   output logic signed [7:0] rsp_move_x,
   output logic signed [7:0] rsp_move_y
);

   // captured item
   logic              mode_ff;
   logic [7:0]        px_ff, py_ff;
   logic              pressed_ff;
   logic signed [12:0] yaw_ff, pitch_ff, tx_ff, tz_ff;
   logic [15:0]       ivl_ff;
   logic [7:0]        last_px_ff, last_py_ff;

   // per axis, lane 0 is x and lane 1 is y
   logic signed [12:0] d_val [2];
   logic [12:0]        d_abs [2];
   logic signed [12:0] tilt  [2];
   logic signed [8:0]  cpos  [2];
   logic signed [8:0]  dpad  [2];
   logic [17:0]        csq   [2];
   logic signed [29:0] lin_prod  [2];
   logic [25:0]        sq_prod   [2];
   logic signed [20:0] tilt_prod [2];
   logic [34:0]        acc_prod  [2];
   logic [20:0]        tilt_mag  [2];
   logic [7:0]         ax_mag    [2];
   logic signed [34:0] curve     [2];
   logic signed [34:0] num_s     [2];
   logic [34:0]        num_abs   [2];
   logic [NUM_W-1:0]   num_mag   [2];
   logic [NUM_W-1:0]   quot      [2];
   logic               done      [2];
   logic [7:0]         move      [2];

   logic signed [25:0] lin_ff  [2];
   logic [24:0]        sq_ff   [2];
   logic               negd_ff [2];
   logic signed [20:0] tp_ff   [2];
   logic [32:0]        acc_ff  [2];
   logic signed [8:0]  ax_ff   [2];
   logic               negq_ff [2];
   logic [7:0]         move_ff [2];

   logic [15:0]        lin_gain;
   logic [9:0]         acc_gain;
   logic [16:0]        radius_sq;
   logic [15:0]        ivl1;
   logic [7:0]         div1;
   logic [DEN_W-1:0]   den;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff    <= req_gyro_mode;
         px_ff      <= req_pad_x;
         py_ff      <= req_pad_y;
         pressed_ff <= req_pad_pressed;
         yaw_ff     <= req_rate_yaw;
         pitch_ff   <= req_rate_pitch;
         tx_ff      <= req_tilt_x;
         tz_ff      <= req_tilt_z;
         ivl_ff     <= req_interval;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_px_ff <= '0;
         last_py_ff <= '0;
      end else if (cmd.save_pad) begin
         last_px_ff <= px_ff;
         last_py_ff <= py_ff;
      end
   end

   assign lin_gain = mode_ff ? {4'b0, cfg.gyro_speed_gain} : cfg.pad_speed_gain;
   assign acc_gain = mode_ff ? {2'b0, cfg.gyro_accel_gain} : cfg.pad_accel_gain;

   always_comb begin
      cpos[0] = $signed({1'b0, px_ff}) - $signed({1'b0, PAD_CENTRE});
      cpos[1] = $signed({1'b0, py_ff}) - $signed({1'b0, PAD_CENTRE});
      dpad[0] = $signed({1'b0, px_ff}) - $signed({1'b0, last_px_ff});
      dpad[1] = $signed({1'b0, py_ff}) - $signed({1'b0, last_py_ff});
      d_val[0] = mode_ff ? yaw_ff : $signed({{4{dpad[0][8]}}, dpad[0]});
      d_val[1] = mode_ff ? pitch_ff : $signed({{4{dpad[1][8]}}, dpad[1]});
      tilt[0]  = tx_ff;
      tilt[1]  = tz_ff;
      for (int i = 0; i < 2; i++) begin
         csq[i]       = 18'(cpos[i] * cpos[i]);
         d_abs[i]     = d_val[i][12] ? 13'(-d_val[i]) : 13'(d_val[i]);
         lin_prod[i]  = 30'(d_val[i]) * 30'($signed({1'b0, lin_gain}));
         sq_prod[i]   = 26'(d_abs[i]) * 26'(d_abs[i]);
         tilt_prod[i] = 21'(tilt[i]) * 21'($signed({1'b0, cfg.tilt_mix_gain}));
         acc_prod[i]  = 35'(sq_ff[i] * acc_gain);
         tilt_mag[i]  = tp_ff[i][20] ? 21'(-tp_ff[i]) : 21'(tp_ff[i]);
         ax_mag[i]    = tilt_mag[i][19:12];
      end
      radius_sq = 17'(csq[0]) + 17'(csq[1]);
   end

   assign status.gyro_mode = mode_ff;
   assign status.pad_zero  = (px_ff == '0) && (py_ff == '0);
   assign status.drag_hit  = pressed_ff && (radius_sq >= DRAG_RADIUS_SQ_MIN);
   assign status.div_done  = done[0] && done[1];

   // first product stage: linear term, square, tilt term
   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         for (int i = 0; i < 2; i++) begin
            lin_ff[i]  <= lin_prod[i][25:0];
            sq_ff[i]   <= sq_prod[i][24:0];
            negd_ff[i] <= d_val[i][12];
            tp_ff[i]   <= tilt_prod[i];
         end
      end
   end

   // second stage: square times gain, tilt term truncated toward zero
   always_ff @(posedge clock) begin
      if (cmd.mul2) begin
         for (int i = 0; i < 2; i++) begin
            acc_ff[i] <= acc_prod[i][32:0];
            ax_ff[i]  <= tp_ff[i][20] ? -$signed({1'b0, ax_mag[i]})
                                      : $signed({1'b0, ax_mag[i]});
         end
      end
   end

   // operand forming for the dividers
   assign ivl1 = (ivl_ff == '0) ? 16'd1 : ivl_ff;
   assign div1 = (cfg.drag_divisor == '0) ? 8'd1 : cfg.drag_divisor;

   always_comb begin
      if (cmd.drag) begin
         den = {20'b0, div1};
      end else if (mode_ff) begin
         den = {ivl1, 12'b0};
      end else begin
         den = {4'b0, ivl1, 8'b0} - {12'b0, ivl1};
      end
      for (int i = 0; i < 2; i++) begin
         curve[i] = $signed({{9{lin_ff[i][25]}}, lin_ff[i]})
                  + (negd_ff[i] ? -$signed({2'b0, acc_ff[i]}) : $signed({2'b0, acc_ff[i]}));
         if (cmd.drag) begin
            num_s[i] = $signed({{26{cpos[i][8]}}, cpos[i]});
         end else if (mode_ff) begin
            num_s[i] = $signed({{26{ax_ff[i][8]}}, ax_ff[i]}) - curve[i];
         end else begin
            num_s[i] = curve[i];
         end
         num_abs[i] = num_s[i][34] ? 35'(-num_s[i]) : 35'(num_s[i]);
         num_mag[i] = num_abs[i][NUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         for (int i = 0; i < 2; i++) begin
            negq_ff[i] <= num_s[i][34];
         end
      end
   end

   for (genvar g = 0; g < 2; g++) begin : g_lane
      pmac_div u_div (
         .clock (clock),
         .reset (reset),
         .start (cmd.div_start),
         .num   (num_mag[g]),
         .den   (den),
         .quot  (quot[g]),
         .done  (done[g])
      );
   end

   // saturate the signed quotient to 8 bits, or force zero for items that move nothing
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         if (cmd.zero) begin
            move[i] = '0;
         end else if (negq_ff[i]) begin
            move[i] = (quot[i] >= NUM_W'(128)) ? 8'h80 : 8'(-quot[i][7:0]);
         end else begin
            move[i] = (quot[i] >= NUM_W'(127)) ? 8'h7f : quot[i][7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         for (int i = 0; i < 2; i++) begin
            move_ff[i] <= move[i];
         end
      end
   end

   assign rsp_move_x = $signed(move_ff[0]);
   assign rsp_move_y = $signed(move_ff[1]);

endmodule

`default_nettype wire

@@ design/pmac_ctrl.sv @@
// controller: item sequencing, tracking state and result handshake
// depends on pmac_pkg
`default_nettype none

module pmac_ctrl import pmac_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PREP1 = 3'd1;
   localparam logic [2:0] S_PREP2 = 3'd2;
   localparam logic [2:0] S_PREP3 = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_WRITE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       pad_tracking_ff, pad_tracking_in;
   logic       gyro_started_ff, gyro_started_in;
   logic       drag_ff, drag_in;
   logic       zero_ff, zero_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in        = state_ff;
      pad_tracking_in = pad_tracking_ff;
      gyro_started_in = gyro_started_ff;
      drag_in         = drag_ff;
      zero_in         = zero_ff;
      cmd             = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_PREP1;
            end
         end
         S_PREP1: begin
            cmd.mul1 = 1'b1;
            drag_in  = 1'b0;
            zero_in  = 1'b1;
            state_in = S_WRITE;
            if (!status.gyro_mode) begin
               if (status.pad_zero) begin
                  pad_tracking_in = 1'b0;
               end else if (!pad_tracking_ff) begin
                  pad_tracking_in = 1'b1;
                  cmd.save_pad    = 1'b1;
               end else begin
                  cmd.save_pad = 1'b1;
                  drag_in      = status.drag_hit;
                  zero_in      = 1'b0;
                  state_in     = S_PREP2;
               end
            end else if (!gyro_started_ff) begin
               gyro_started_in = 1'b1;
            end else begin
               zero_in  = 1'b0;
               state_in = S_PREP2;
            end
         end
         S_PREP2: begin
            cmd.mul2 = 1'b1;
            state_in = S_PREP3;
         end
         S_PREP3: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      cmd.drag = drag_ff;
      cmd.zero = zero_ff;
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         pad_tracking_ff <= 1'b0;
         gyro_started_ff <= 1'b0;
         drag_ff         <= 1'b0;
         zero_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         pad_tracking_ff <= pad_tracking_in;
         gyro_started_ff <= gyro_started_in;
         drag_ff         <= drag_in;
         zero_ff         <= zero_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // a new result never overwrites one still held by a stall
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

   a_accept_seq: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> (state_ff == S_PREP1))
      else $error("accepted item not sequenced");

   a_untouch_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PREP1 && !status.gyro_mode && status.pad_zero)
      |=> (!pad_tracking_ff && zero_ff && state_ff == S_WRITE))
      else $error("untouched pad did not clear tracking");

   a_div_follow: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> (state_ff == S_DIV && !status.div_done))
      else $error("divider start out of sequence");

endmodule

`default_nettype wire
